[src/ftpe_pkg.sv]
// shared types and constants for the fenwick tree prefix engine
// no dependencies; imported by fenwick_tree_prefix_engine
package ftpe_pkg;

   localparam int unsigned IDX_W  = 15;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned REQ_W  = 48;   // index + value, padded to whole bytes

   typedef enum logic [0:0] {
      FUNC_UPDATE = 1'b0,
      FUNC_QUERY  = 1'b1
   } func_type;

   typedef enum logic [0:0] {
      MODE_SUM = 1'b0,
      MODE_MAX = 1'b1
   } mode_type;

endpackage

[src/fenwick_tree_prefix_engine.sv]
// fenwick_tree_prefix_engine: binary indexed tree with prefix sum / prefix max
// depends on ftpe_pkg (types, field widths); tree store is an in-module memory
// operation: accept a request when idle, then one memory read per tree node walked, then
// drain the last read; a query walks popcount(index+1) nodes, an update up to log2(SIZE)+1
// transactions: one at a time; a finished query also waits while the response is stalled
// reset: mode goes to sum, then a clearing pass zeroes the store
module fenwick_tree_prefix_engine #(
   parameter int unsigned SIZE = 32768
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = index[14:0], value[46:15], zero pad [47]; tuser = func
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ftpe_pkg::REQ_W-1:0]       req_tdata,
   input  ftpe_pkg::func_type               req_tuser,
   // response: tdata = result[31:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ftpe_pkg::DATA_W-1:0]      rsp_tdata,
   // mode register: 0 sum, 1 max
   input  logic                             csr_wr_en,
   input  logic [0:0]                       csr_wr_data
);
   import ftpe_pkg::*;

   // address of an entry, node value (up to 2*SIZE), and a compare width wide
   // enough for both the node and the incoming index plus one
   localparam int unsigned AW  = $clog2(SIZE);
   localparam int unsigned NXW = $clog2(SIZE) + 2;
   localparam int unsigned CW  = (NXW > IDX_W + 1) ? NXW : IDX_W + 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } state_type;

   // tree store, node n held at entry n-1
   logic [DATA_W-1:0] mem [SIZE];

   state_type          state_ff,     state_in;
   mode_type           mode_ff,      mode_in;
   logic [AW-1:0]      clr_addr_ff,  clr_addr_in;
   logic [NXW-1:0]     node_ff,      node_in;
   logic               is_query_ff,  is_query_in;
   logic [DATA_W-1:0]  val_ff,       val_in;
   logic [DATA_W-1:0]  acc_ff,       acc_in;
   logic               rd_pend_ff,   rd_pend_in;
   logic [AW-1:0]      wb_addr_ff,   wb_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff,  rsp_data_in;
   logic [DATA_W-1:0]  rd_data_ff;

   // memory port controls
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [DATA_W-1:0]  mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;

   // walk helpers
   logic [CW-1:0]      idx_ext;
   logic               idx_in_range;
   logic [NXW-1:0]     start_node;
   logic [NXW-1:0]     low_bit;
   logic               walk_live;
   logic [DATA_W-1:0]  combined;
   logic               out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an out-of-range update walks nothing; an out-of-range query covers the whole tree
   assign idx_ext      = CW'(req_tdata[IDX_W-1:0]);
   assign idx_in_range = (idx_ext < CW'(SIZE));
   always_comb begin
      if (idx_in_range) begin
         start_node = NXW'(idx_ext + CW'(1));
      end else if (req_tuser == FUNC_QUERY) begin
         start_node = NXW'(SIZE);
      end else begin
         start_node = NXW'(SIZE + 1);
      end
   end

   assign low_bit   = node_ff & (~node_ff + NXW'(1));
   assign walk_live = is_query_ff ? (node_ff != '0) : (node_ff <= NXW'(SIZE));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // shared combine unit: add, or signed max; the update folds the value into
   // the node just read, the query folds the node into the accumulator
   always_comb begin
      logic [DATA_W-1:0] opa;
      logic [DATA_W-1:0] opb;
      opa = is_query_ff ? rd_data_ff : val_ff;
      opb = is_query_ff ? acc_ff     : rd_data_ff;
      if (mode_ff == MODE_SUM) begin
         combined = opa + opb;
      end else begin
         combined = ($signed(opa) > $signed(opb)) ? opa : opb;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      clr_addr_in  = clr_addr_ff;
      node_in      = node_ff;
      is_query_in  = is_query_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      rd_pend_in   = 1'b0;
      wb_addr_in   = wb_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = wb_addr_ff;
      mem_wdata    = combined;
      mem_re       = 1'b0;
      mem_raddr    = AW'(node_ff - NXW'(1));

      if (csr_wr_en) begin
         mode_in = mode_type'(csr_wr_data);
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               is_query_in = (req_tuser == FUNC_QUERY);
               val_in      = req_tdata[IDX_W +: DATA_W];
               node_in     = start_node;
               acc_in      = '0;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            // retire the node read last cycle
            if (rd_pend_ff) begin
               if (is_query_ff) begin
                  acc_in = combined;
               end else begin
                  mem_we = 1'b1;
               end
            end
            // issue the next node, one read per cycle
            if (walk_live) begin
               mem_re     = 1'b1;
               rd_pend_in = 1'b1;
               wb_addr_in = mem_raddr;
               node_in    = is_query_ff ? (node_ff - low_bit) : (node_ff + low_bit);
            end else if (!rd_pend_ff) begin
               if (!is_query_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = acc_ff;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mode_ff      <= MODE_SUM;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff     <= node_in;
      is_query_ff <= is_query_in;
      val_ff      <= val_in;
      acc_ff      <= acc_in;
      wb_addr_ff  <= wb_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // tree store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // no transaction taken while the store is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request accepted during clearing pass");

   // a pending read only exists inside a walk
   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_WALK))
      else $error("read retired outside a walk");

   // queries never modify the store
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && mem_we) |-> !is_query_ff)
      else $error("store written during a query walk");

   // a finished query leaves a result in the output register
   a_query_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && is_query_ff && (state_in == ST_IDLE)) |=> rsp_valid_ff)
      else $error("query finished without a result");

endmodule
